// ===== hw/rtl/complex_arith_unit_assert.svh =====
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/cau_pkg.sv =====
`default_nettype none
package cau_pkg;
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 28;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int SUM_W      = PROD_W + 2;
   localparam int MAG_W      = PROD_W + 1;
   localparam int REM_W      = MAG_W + DATA_WIDTH;
   localparam int QUO_BITS   = DATA_WIDTH;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_DIV = 2'd2,
      OP_SQR = 2'd3
   } op_type;

   typedef struct packed {
      logic                  vld;
      logic                  div;
      logic                  dz;
      logic                  neg_re;
      logic                  neg_im;
      logic                  ovf_re;
      logic                  ovf_im;
      logic [REM_W-1:0]      rem_re;
      logic [REM_W-1:0]      rem_im;
      logic [REM_W-1:0]      dsh;
      logic [QUO_BITS-1:0]   q_re;
      logic [QUO_BITS-1:0]   q_im;
   } cell_type;
endpackage
`default_nettype wire

// ===== hw/rtl/complex_arith_unit.sv =====
// channel  | handshake             | payload
// req_     | req_valid/req_ready   | op, a_re, a_im, b_re, b_im
// rsp_     | rsp_valid/rsp_ready   | res_re, res_im, div_zero, overflow
//
// one transaction per cycle while the output register is empty or taken;
// 37 register stages: 4 front stages (capture, multiply, sum,
// sign/magnitude), 32 division cells of one quotient bit each, one output
// register
// the whole pipeline advances when the output register is empty or taken
// synchronous active-high reset clears all valid bits
`default_nettype none
module complex_arith_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_op,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0] req_a_re,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0] req_a_im,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0] req_b_re,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0] req_b_im,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [cau_pkg::DATA_WIDTH-1:0]      rsp_res_re,
   output logic [cau_pkg::DATA_WIDTH-1:0]      rsp_res_im,
   output logic                                rsp_div_zero,
   output logic                                rsp_overflow
);
   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int NC = cau_pkg::QUO_BITS;

   logic                en;
   cau_pkg::cell_type   chain [NC+1];
   cau_pkg::cell_type   last;
   logic                sat_re, sat_im;
   logic [DW-1:0]       lim_re, lim_im;
   logic                vld_ff;
   logic [DW-1:0]       re_ff, im_ff, re_in, im_in;
   logic                dz_ff, ovf_ff;

   assign en        = !vld_ff || rsp_ready;
   assign req_ready = en;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_a_re  (req_a_re),
      .req_a_im  (req_a_im),
      .req_b_re  (req_b_re),
      .req_b_im  (req_b_im),
      .cell_out  (chain[0])
   );

   for (genvar i = 0; i < NC; i++) begin : g_cell
      cau_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign last = chain[NC];

   // saturation limits
   always_comb begin
      lim_re = last.neg_re ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      lim_im = last.neg_im ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      sat_re = last.ovf_re || (last.q_re > lim_re);
      sat_im = last.ovf_im || (last.q_im > lim_im);
      re_in  = sat_re ? lim_re : (last.neg_re ? DW'(-last.q_re) : last.q_re);
      im_in  = sat_im ? lim_im : (last.neg_im ? DW'(-last.q_im) : last.q_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= last.vld;
         re_ff  <= re_in;
         im_ff  <= im_in;
         dz_ff  <= last.dz;
         ovf_ff <= sat_re || sat_im;
      end
   end

   assign rsp_valid    = vld_ff;
   assign rsp_res_re   = re_ff;
   assign rsp_res_im   = im_ff;
   assign rsp_div_zero = dz_ff;
   assign rsp_overflow = ovf_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/cau_front.sv =====
`default_nettype none
module cau_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              req_valid,
   input  wire logic [1:0]                        req_op,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0]    req_a_re,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0]    req_a_im,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0]    req_b_re,
   input  wire logic [cau_pkg::DATA_WIDTH-1:0]    req_b_im,
   output cau_pkg::cell_type                      cell_out
);
   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int PW = cau_pkg::PROD_W;
   localparam int SW = cau_pkg::SUM_W;
   localparam int MW = cau_pkg::MAG_W;
   localparam int RW = cau_pkg::REM_W;

   // stage 1: input capture
   logic                  v1_ff;
   cau_pkg::op_type       op1_ff;
   logic signed [DW-1:0]  ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // stage 2: products, and operand sums for add
   logic                  v2_ff;
   cau_pkg::op_type       op2_ff;
   logic signed [PW-1:0]  m0_ff, m1_ff, m2_ff, m3_ff, p4_ff, p5_ff;
   logic signed [PW-1:0]  m0_in, m1_in, m2_in, m3_in, p4_in, p5_in;
   logic signed [DW:0]    sr2_ff, si2_ff, sr2_in, si2_in;

   // stage 3: sums
   logic                  v3_ff;
   cau_pkg::op_type       op3_ff;
   logic signed [SW-1:0]  sr3_ff, si3_ff, sr3_in, si3_in;
   logic [MW-1:0]         den3_ff, den3_in;

   // stage 4: sign and magnitude
   cau_pkg::cell_type     c4_ff, c4_in;
   logic [SW-1:0]         abs_re, abs_im;
   logic [MW-1:0]         mag_re, mag_im, scl_re, scl_im;
   logic                  is_div, dz;

   always_comb begin
      m0_in  = PW'(ar1_ff) * PW'((op1_ff == cau_pkg::OP_SQR) ? ar1_ff : br1_ff);
      m1_in  = PW'(ai1_ff) * PW'((op1_ff == cau_pkg::OP_SQR) ? ai1_ff : bi1_ff);
      m2_in  = PW'(ai1_ff) * PW'((op1_ff == cau_pkg::OP_SQR) ? ar1_ff : br1_ff);
      m3_in  = PW'(ar1_ff) * PW'((op1_ff == cau_pkg::OP_SQR) ? ai1_ff : bi1_ff);
      p4_in  = PW'(br1_ff) * PW'(br1_ff);
      p5_in  = PW'(bi1_ff) * PW'(bi1_ff);
      sr2_in = (DW+1)'(ar1_ff) + (DW+1)'(br1_ff);
      si2_in = (DW+1)'(ai1_ff) + (DW+1)'(bi1_ff);
   end

   always_comb begin
      den3_in = {1'b0, p4_ff} + {1'b0, p5_ff};
      case (op2_ff)
         cau_pkg::OP_ADD: begin
            sr3_in = SW'(sr2_ff);
            si3_in = SW'(si2_ff);
         end
         cau_pkg::OP_DIV: begin
            sr3_in = SW'(m0_ff) + SW'(m1_ff);
            si3_in = SW'(m2_ff) - SW'(m3_ff);
         end
         default: begin
            sr3_in = SW'(m0_ff) - SW'(m1_ff);
            si3_in = SW'(m2_ff) + SW'(m3_ff);
         end
      endcase
   end

   always_comb begin
      abs_re = sr3_ff[SW-1] ? SW'(-sr3_ff) : SW'(sr3_ff);
      abs_im = si3_ff[SW-1] ? SW'(-si3_ff) : SW'(si3_ff);
      mag_re = abs_re[MW-1:0];
      mag_im = abs_im[MW-1:0];
      scl_re = (op3_ff == cau_pkg::OP_ADD) ? mag_re : (mag_re >> cau_pkg::FRAC_BITS);
      scl_im = (op3_ff == cau_pkg::OP_ADD) ? mag_im : (mag_im >> cau_pkg::FRAC_BITS);
      dz     = (op3_ff == cau_pkg::OP_DIV) && (den3_ff == '0);
      is_div = (op3_ff == cau_pkg::OP_DIV) && !dz;
      c4_in.vld    = v3_ff;
      c4_in.div    = is_div;
      c4_in.dz     = dz;
      c4_in.neg_re = sr3_ff[SW-1] && !dz;
      c4_in.neg_im = si3_ff[SW-1] && !dz;
      c4_in.rem_re = RW'(mag_re) << cau_pkg::FRAC_BITS;
      c4_in.rem_im = RW'(mag_im) << cau_pkg::FRAC_BITS;
      c4_in.dsh    = RW'(den3_ff) << (cau_pkg::QUO_BITS - 1);
      if (dz) begin
         c4_in.ovf_re = 1'b0;
         c4_in.ovf_im = 1'b0;
         c4_in.q_re   = '0;
         c4_in.q_im   = '0;
      end else if (is_div) begin
         // quotient reaches 2^32 exactly when mag >= den * 16
         c4_in.ovf_re = (RW'(mag_re) << cau_pkg::FRAC_BITS)
                        >= (RW'(den3_ff) << cau_pkg::QUO_BITS);
         c4_in.ovf_im = (RW'(mag_im) << cau_pkg::FRAC_BITS)
                        >= (RW'(den3_ff) << cau_pkg::QUO_BITS);
         c4_in.q_re   = '0;
         c4_in.q_im   = '0;
      end else begin
         c4_in.ovf_re = |scl_re[MW-1:cau_pkg::QUO_BITS];
         c4_in.ovf_im = |scl_im[MW-1:cau_pkg::QUO_BITS];
         c4_in.q_re   = scl_re[cau_pkg::QUO_BITS-1:0];
         c4_in.q_im   = scl_im[cau_pkg::QUO_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         c4_ff.vld <= 1'b0;
      end else if (en) begin
         v1_ff  <= req_valid;
         op1_ff <= cau_pkg::op_type'(req_op);
         ar1_ff <= req_a_re;
         ai1_ff <= req_a_im;
         br1_ff <= req_b_re;
         bi1_ff <= req_b_im;
         v2_ff  <= v1_ff;
         op2_ff <= op1_ff;
         m0_ff  <= m0_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         p4_ff  <= p4_in;
         p5_ff  <= p5_in;
         sr2_ff <= sr2_in;
         si2_ff <= si2_in;
         v3_ff   <= v2_ff;
         op3_ff  <= op2_ff;
         sr3_ff  <= sr3_in;
         si3_ff  <= si3_in;
         den3_ff <= den3_in;
         c4_ff   <= c4_in;
      end
   end

   assign cell_out = c4_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/cau_cell.sv =====
`default_nettype none
module cau_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire cau_pkg::cell_type cell_in,
   output cau_pkg::cell_type      cell_out
);
   cau_pkg::cell_type st_ff, st_in;
   logic              ge_re, ge_im;

   always_comb begin
      st_in = cell_in;
      ge_re = cell_in.rem_re >= cell_in.dsh;
      ge_im = cell_in.rem_im >= cell_in.dsh;
      if (cell_in.div) begin
         st_in.rem_re = ge_re ? cell_in.rem_re - cell_in.dsh : cell_in.rem_re;
         st_in.rem_im = ge_im ? cell_in.rem_im - cell_in.dsh : cell_in.rem_im;
         st_in.q_re   = {cell_in.q_re[cau_pkg::QUO_BITS-2:0], ge_re};
         st_in.q_im   = {cell_in.q_im[cau_pkg::QUO_BITS-2:0], ge_im};
         st_in.dsh    = cell_in.dsh >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.vld <= 1'b0;
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   assign cell_out = st_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/cau_checker.sv =====
`default_nettype none
`include "complex_arith_unit_assert.svh"
module cau_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [cau_pkg::DATA_WIDTH-1:0] rsp_res_re,
   input wire logic [cau_pkg::DATA_WIDTH-1:0] rsp_res_im,
   input wire logic                           rsp_div_zero,
   input wire logic                           rsp_overflow
);
   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   `CAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_res_re) && $stable(rsp_res_im))
   `CAU_ASSERT_NOW(a_dz_zero, rsp_valid && rsp_div_zero, rsp_res_re == '0 && rsp_res_im == '0 && !rsp_overflow)
   `CAU_ASSERT_NOW(a_ovf_limit, rsp_valid && rsp_overflow, rsp_res_re == MAXV || rsp_res_re == MINV || rsp_res_im == MAXV || rsp_res_im == MINV)
   `CAU_ASSERT_NOW(a_ready, 1'b1, req_ready == (!rsp_valid || rsp_ready))
endmodule

bind complex_arith_unit cau_checker u_cau_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_res_re   (rsp_res_re),
   .rsp_res_im   (rsp_res_im),
   .rsp_div_zero (rsp_div_zero),
   .rsp_overflow (rsp_overflow)
);
`default_nettype wire
